@@ rtl/stepper_trapezoid_step_planner_defines.svh @@
// Assertion macros of the step planner top level.
`ifndef STEPPER_TRAPEZOID_STEP_PLANNER_DEFINES_SVH
`define STEPPER_TRAPEZOID_STEP_PLANNER_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define STP_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define STP_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/stp_pkg.sv @@
// Shared types, widths and constants of the step planner.
`timescale 1ns / 1ps
package stp_pkg;

  localparam int POS_W   = 24;               // position width, sixteenth steps
  localparam int SPD_W   = 16;               // speed width, rpm*16
  localparam int CFG_W   = 16;               // width of speed and span registers
  localparam int ANG_W   = 19;               // step angle register width
  localparam int THR_W   = 32;               // threshold register width
  localparam int LOW_W   = 20;               // low time width
  localparam int A_W     = 32;               // step_angle_milli * 8000
  localparam int PROD_W  = POS_W + CFG_W;    // |d| * |max - min|
  localparam int DVD_W   = PROD_W;           // divider dividend width
  localparam int DVS_W   = SPD_W + 6;        // divider divisor width, 3*16*speed
  localparam int CNT_W   = $clog2(DVD_W + 1);
  localparam int SUM_W   = DVD_W + 2;
  localparam int EXT_W   = POS_W + 2;
  localparam int ADDR_W  = 5;
  localparam int DATA_W  = 32;

  localparam int IN_W    = ((3 * POS_W + 7) / 8) * 8;
  localparam int OFS_STEP = 0;
  localparam int OFS_DIR  = 1;
  localparam int OFS_CHG  = 2;
  localparam int OFS_MS   = 3;
  localparam int OFS_SPD  = 6;
  localparam int OFS_LOW  = OFS_SPD + SPD_W;
  localparam int OFS_POS  = OFS_LOW + LOW_W;
  localparam int OUT_W    = ((OFS_POS + POS_W + 7) / 8) * 8;

  localparam int LOW_MAX     = 1000000;
  localparam int ANGLE_SCALE = 8000;
  localparam logic [SPD_W-1:0] SPD_TOP = '1;

  localparam logic [CFG_W-1:0]  RESET_ACCEL_SPAN = 16'd1600;
  localparam logic [CFG_W-1:0]  RESET_MIN_SPEED  = 16'd480;
  localparam logic [CFG_W-1:0]  RESET_MAX_SPEED  = 16'd9600;
  localparam logic [CFG_W-1:0]  RESET_PULSE_HIGH = 16'd2;
  localparam logic [ANG_W-1:0]  RESET_ANGLE      = 19'd1800;
  localparam logic [THR_W-1:0]  RESET_FINE       = 32'd125830080;
  localparam logic [THR_W-1:0]  RESET_COARSE     = 32'd503320320;
  localparam int                RESET_SPEED      = 1920;

  // Microstep modes; the code is log2 of the division.
  typedef enum logic [2:0] {
    MODE_FULL      = 3'd0,
    MODE_HALF      = 3'd1,
    MODE_QUARTER   = 3'd2,
    MODE_EIGHTH    = 3'd3,
    MODE_SIXTEENTH = 3'd4
  } mode_t;

  localparam logic [2:0] PINS_FULL      = 3'b000;
  localparam logic [2:0] PINS_HALF      = 3'b001;
  localparam logic [2:0] PINS_QUARTER   = 3'b010;
  localparam logic [2:0] PINS_EIGHTH    = 3'b011;
  localparam logic [2:0] PINS_SIXTEENTH = 3'b111;

  typedef enum logic [2:0] {
    REG_ACCEL_SPAN = 3'd0,
    REG_MIN_SPEED  = 3'd1,
    REG_MAX_SPEED  = 3'd2,
    REG_CW_POS     = 3'd3,
    REG_PULSE_HIGH = 3'd4,
    REG_ANGLE      = 3'd5,
    REG_FINE       = 3'd6,
    REG_COARSE     = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [CFG_W-1:0] accel_span;
    logic [CFG_W-1:0] min_speed;
    logic [CFG_W-1:0] max_speed;
    logic             cw_positive;
    logic [CFG_W-1:0] pulse_high_us;
    logic [ANG_W-1:0] step_angle_milli;
    logic [THR_W-1:0] fine_thresholds;
    logic [THR_W-1:0] coarse_thresholds;
  } cfg_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic capture;
    logic load_commit;
    logic geo;
    logic sel;
    logic mul;
    logic div_start;
    logic div_pass2;
    logic spd;
    logic mode;
    logic fin;
  } stp_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic div_done;
  } stp_stat_t;

  function automatic logic [2:0] mode_pins(input mode_t m);
    logic [2:0] pins;
    case (m)
      MODE_HALF:      pins = PINS_HALF;
      MODE_QUARTER:   pins = PINS_QUARTER;
      MODE_EIGHTH:    pins = PINS_EIGHTH;
      MODE_SIXTEENTH: pins = PINS_SIXTEENTH;
      default:        pins = PINS_FULL;
    endcase
    return pins;
  endfunction

endpackage

@@ rtl/stp_div.sv @@
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module stp_div import stp_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  input  logic [CNT_W-1:0] iters,
  output logic             done,
  output logic [DVD_W-1:0] quotient
);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [DVD_W-1:0] dvd;
  logic [DVS_W-1:0] rem;
  logic [DVS_W-1:0] dvs;
  logic [DVS_W:0]   trial;
  logic [DVS_W:0]   diff;
  logic             fits;
  logic [DVS_W-1:0] rem_next;

  assign trial    = {rem, dvd[DVD_W-1]};
  assign diff     = trial - {1'b0, dvs};
  assign fits     = trial >= {1'b0, dvs};
  assign rem_next = fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= iters;
    end else if (busy) begin
      cnt <= cnt - CNT_W'(1);
      if (cnt == CNT_W'(1)) busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      dvd <= {dvd[DVD_W-2:0], fits};
      rem <= rem_next;
    end
  end

  assign done     = busy && (cnt == CNT_W'(1));
  assign quotient = dvd;

endmodule

@@ rtl/stp_ctrl.sv @@
// Sequencer of the step planner: handshakes and datapath commands.
`timescale 1ns / 1ps
module stp_ctrl import stp_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      s_tvalid,
  input  logic      s_cmd,
  output logic      s_tready,
  output logic      m_tvalid,
  input  logic      m_tready,
  output stp_cmd_t  cmd,
  input  stp_stat_t stat
);

  typedef enum logic [11:0] {
    S_IDLE = 12'b000000000001,
    S_LOAD = 12'b000000000010,
    S_GEO  = 12'b000000000100,
    S_SEL  = 12'b000000001000,
    S_MUL  = 12'b000000010000,
    S_D1S  = 12'b000000100000,
    S_D1W  = 12'b000001000000,
    S_SPD  = 12'b000010000000,
    S_MODE = 12'b000100000000,
    S_D2S  = 12'b001000000000,
    S_D2W  = 12'b010000000000,
    S_FIN  = 12'b100000000000
  } state_t;

  state_t state, state_next;
  logic   out_free;

  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.capture = 1'b1;
          state_next  = s_cmd ? S_LOAD : S_GEO;
        end
      end
      S_LOAD: begin
        if (out_free) begin
          cmd.load_commit = 1'b1;
          state_next      = S_IDLE;
        end
      end
      S_GEO: begin
        cmd.geo    = 1'b1;
        state_next = S_SEL;
      end
      S_SEL: begin
        cmd.sel    = 1'b1;
        state_next = S_MUL;
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_D1S;
      end
      S_D1S: begin
        cmd.div_start = 1'b1;
        state_next    = S_D1W;
      end
      S_D1W: begin
        if (stat.div_done) state_next = S_SPD;
      end
      S_SPD: begin
        cmd.spd    = 1'b1;
        state_next = S_MODE;
      end
      S_MODE: begin
        cmd.mode   = 1'b1;
        state_next = S_D2S;
      end
      S_D2S: begin
        cmd.div_start = 1'b1;
        cmd.div_pass2 = 1'b1;
        state_next    = S_D2W;
      end
      S_D2W: begin
        if (stat.div_done) state_next = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          cmd.fin    = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_commit || cmd.fin) m_tvalid <= 1'b1;
      else if (m_tready)              m_tvalid <= 1'b0;
    end
  end

endmodule

@@ rtl/stp_dp.sv @@
// Datapath of the step planner: ramp geometry, speed, mode, low time, position.
`timescale 1ns / 1ps
module stp_dp import stp_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  cfg_t             cfg,
  input  stp_cmd_t         cmd,
  output stp_stat_t        stat,
  input  logic [IN_W-1:0]  s_tdata,
  output logic [OUT_W-1:0] m_tdata
);

  localparam logic [4:0] SIXTEENTHS = 5'd16;

  // Captured word
  logic signed [POS_W-1:0] st_q, tg_q, newpos_q;

  // Architectural state, also the output word
  logic signed [POS_W-1:0] position;
  logic                    direction;
  mode_t                   step_mode;
  logic [SPD_W-1:0]        speed;
  logic [LOW_W-1:0]        low_time;
  logic                    o_step, o_chg;

  // Work registers
  logic                    up_q, cruise_q, neg_q, zero_q;
  logic [CFG_W-1:0]        acc_q;
  logic signed [POS_W:0]   d_q;
  logic signed [CFG_W:0]   diff_q;
  logic [PROD_W-1:0]       prod_q;
  logic [SPD_W-1:0]        spd_q;
  mode_t                   code_q;
  logic [DVS_W-1:0]        den_q;
  logic [A_W-1:0]          angle_q;

  // Geometry
  logic signed [POS_W:0]   dist_s;
  logic [POS_W-1:0]        dist_mag;
  logic                    dist_lt;
  logic [CFG_W-1:0]        acc_next;
  logic [CFG_W-1:0]        span_eff;

  always_comb begin
    dist_s   = {tg_q[POS_W-1], tg_q} - {st_q[POS_W-1], st_q};
    dist_mag = dist_s[POS_W] ? POS_W'(-dist_s) : dist_s[POS_W-1:0];
    dist_lt  = {1'b0, dist_mag} < (POS_W+1)'({cfg.accel_span, 1'b0});
    acc_next = dist_lt ? CFG_W'(dist_mag >> 1) : cfg.accel_span;
    span_eff = (cfg.accel_span == '0) ? CFG_W'(1) : cfg.accel_span;
  end

  // Region select
  logic signed [EXT_W-1:0] pe, se, te, ae;
  logic                    lo_hit, hi_hit;
  logic signed [POS_W:0]   d_next;
  logic signed [CFG_W:0]   diff_next;

  always_comb begin
    pe = EXT_W'(position);
    se = EXT_W'(st_q);
    te = EXT_W'(tg_q);
    ae = $signed(EXT_W'(acc_q));
    if (up_q) begin
      lo_hit = pe < se + ae;
      hi_hit = pe > te - ae;
    end else begin
      lo_hit = pe > se - ae;
      hi_hit = pe < te + ae;
    end
    if (lo_hit)      d_next = (POS_W+1)'(up_q ? pe - se : se - pe);
    else if (hi_hit) d_next = (POS_W+1)'(up_q ? te - pe : pe - te);
    else             d_next = '0;
    diff_next = $signed({1'b0, cfg.max_speed}) - $signed({1'b0, cfg.min_speed});
  end

  // Multiply magnitudes
  logic [POS_W-1:0]  d_mag;
  logic [CFG_W-1:0]  diff_mag;
  logic [PROD_W-1:0] prod_next;

  assign d_mag     = d_q[POS_W] ? POS_W'(-d_q) : d_q[POS_W-1:0];
  assign diff_mag  = diff_q[CFG_W] ? CFG_W'(-diff_q) : diff_q[CFG_W-1:0];
  assign prod_next = d_mag * diff_mag;

  // Shared divider
  logic [DVD_W-1:0] div_dvd, div_q;
  logic [DVS_W-1:0] div_dvs;
  logic [CNT_W-1:0] div_iters;

  assign div_dvd   = cmd.div_pass2 ? (DVD_W'(angle_q) << (DVD_W - A_W)) : prod_q;
  assign div_dvs   = cmd.div_pass2 ? den_q : DVS_W'(span_eff);
  assign div_iters = cmd.div_pass2 ? CNT_W'(A_W) : CNT_W'(DVD_W);

  stp_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .iters    (div_iters),
    .done     (stat.div_done),
    .quotient (div_q)
  );

  // Speed
  logic signed [SUM_W-1:0] q_s, sum_s;
  logic [SPD_W-1:0]        ramp_spd, cruise_spd, spd_next;

  always_comb begin
    q_s   = $signed(SUM_W'(div_q));
    sum_s = $signed(SUM_W'(cfg.min_speed)) + (neg_q ? -q_s : q_s);
    if (sum_s < 0)                             ramp_spd = '0;
    else if (sum_s > $signed(SUM_W'(SPD_TOP))) ramp_spd = SPD_TOP;
    else                                       ramp_spd = sum_s[SPD_W-1:0];
    if ((SPD_W+CFG_W)'(cfg.max_speed) > (SPD_W+CFG_W)'(SPD_TOP)) cruise_spd = SPD_TOP;
    else cruise_spd = SPD_W'(cfg.max_speed);
    spd_next = cruise_q ? cruise_spd : ramp_spd;
  end

  // Mode, divisor and dividend of the low time
  localparam int CMP_W = SPD_W + CFG_W;
  mode_t            code_next;
  logic [DVS_W-1:0] three_s, den_next;
  logic [A_W-1:0]   angle_next;

  always_comb begin
    if (CMP_W'(spd_q) <= CMP_W'(cfg.fine_thresholds[15:0]))
      code_next = MODE_SIXTEENTH;
    else if (CMP_W'(spd_q) <= CMP_W'(cfg.fine_thresholds[31:16]))
      code_next = MODE_EIGHTH;
    else if (CMP_W'(spd_q) <= CMP_W'(cfg.coarse_thresholds[15:0]))
      code_next = MODE_QUARTER;
    else if (CMP_W'(spd_q) <= CMP_W'(cfg.coarse_thresholds[31:16]))
      code_next = MODE_HALF;
    else
      code_next = MODE_FULL;
    three_s    = DVS_W'(spd_q) + DVS_W'({spd_q, 1'b0});
    den_next   = three_s << code_next;
    angle_next = A_W'(cfg.step_angle_milli) * A_W'(ANGLE_SCALE);
  end

  // Low time = floor(angle*8000 / den) - pulse_high, clamped
  logic signed [A_W+1:0]   low_diff;
  logic [LOW_W-1:0]        low_next;
  logic signed [POS_W-1:0] inc, pos_next;
  logic                    dir_next;

  always_comb begin
    low_diff = $signed({2'b00, div_q[A_W-1:0]}) - $signed((A_W+2)'(cfg.pulse_high_us));
    if (zero_q)                                      low_next = LOW_W'(LOW_MAX);
    else if (low_diff < 0)                           low_next = '0;
    else if (low_diff > $signed((A_W+2)'(LOW_MAX))) low_next = LOW_W'(LOW_MAX);
    else                                             low_next = low_diff[LOW_W-1:0];
    inc      = $signed(POS_W'(SIXTEENTHS >> code_q));
    pos_next = up_q ? position + inc : position - inc;
    dir_next = up_q ? cfg.cw_positive : !cfg.cw_positive;
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      st_q     <= s_tdata[POS_W-1:0];
      tg_q     <= s_tdata[2*POS_W-1:POS_W];
      newpos_q <= s_tdata[3*POS_W-1:2*POS_W];
    end
    if (cmd.geo) begin
      up_q  <= st_q < tg_q;
      acc_q <= acc_next;
    end
    if (cmd.sel) begin
      d_q      <= d_next;
      cruise_q <= !lo_hit && !hi_hit;
      diff_q   <= diff_next;
    end
    if (cmd.mul) begin
      prod_q <= prod_next;
      neg_q  <= d_q[POS_W] ^ diff_q[CFG_W];
    end
    if (cmd.spd) spd_q <= spd_next;
    if (cmd.mode) begin
      code_q  <= code_next;
      den_q   <= den_next;
      angle_q <= angle_next;
      zero_q  <= (spd_q == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position  <= '0;
      direction <= 1'b0;
      step_mode <= MODE_FULL;
      speed     <= SPD_W'(RESET_SPEED);
      low_time  <= '0;
      o_step    <= 1'b0;
      o_chg     <= 1'b0;
    end else if (cmd.fin) begin
      position  <= pos_next;
      o_chg     <= dir_next != direction;
      direction <= dir_next;
      step_mode <= code_q;
      speed     <= spd_q;
      low_time  <= low_next;
      o_step    <= 1'b1;
    end else if (cmd.load_commit) begin
      position <= newpos_q;
      o_step   <= 1'b0;
      o_chg    <= 1'b0;
    end
  end

  assign m_tdata = OUT_W'({position, low_time, speed, mode_pins(step_mode),
                           o_chg, direction, o_step});

endmodule

@@ rtl/stp_regs.sv @@
// Configuration register file behind the APB port.
`timescale 1ns / 1ps
module stp_regs import stp_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output cfg_t              cfg
);

  reg_idx_t idx;
  logic     wr;

  assign idx = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.accel_span        <= RESET_ACCEL_SPAN;
      cfg.min_speed         <= RESET_MIN_SPEED;
      cfg.max_speed         <= RESET_MAX_SPEED;
      cfg.cw_positive       <= 1'b1;
      cfg.pulse_high_us     <= RESET_PULSE_HIGH;
      cfg.step_angle_milli  <= RESET_ANGLE;
      cfg.fine_thresholds   <= RESET_FINE;
      cfg.coarse_thresholds <= RESET_COARSE;
    end else if (wr) begin
      unique case (idx)
        REG_ACCEL_SPAN: cfg.accel_span        <= pwdata[CFG_W-1:0];
        REG_MIN_SPEED:  cfg.min_speed         <= pwdata[CFG_W-1:0];
        REG_MAX_SPEED:  cfg.max_speed         <= pwdata[CFG_W-1:0];
        REG_CW_POS:     cfg.cw_positive       <= pwdata[0];
        REG_PULSE_HIGH: cfg.pulse_high_us     <= pwdata[CFG_W-1:0];
        REG_ANGLE:      cfg.step_angle_milli  <= pwdata[ANG_W-1:0];
        REG_FINE:       cfg.fine_thresholds   <= pwdata[THR_W-1:0];
        REG_COARSE:     cfg.coarse_thresholds <= pwdata[THR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_ACCEL_SPAN: prdata = DATA_W'(cfg.accel_span);
      REG_MIN_SPEED:  prdata = DATA_W'(cfg.min_speed);
      REG_MAX_SPEED:  prdata = DATA_W'(cfg.max_speed);
      REG_CW_POS:     prdata = DATA_W'(cfg.cw_positive);
      REG_PULSE_HIGH: prdata = DATA_W'(cfg.pulse_high_us);
      REG_ANGLE:      prdata = DATA_W'(cfg.step_angle_milli);
      REG_FINE:       prdata = DATA_W'(cfg.fine_thresholds);
      REG_COARSE:     prdata = DATA_W'(cfg.coarse_thresholds);
      default:        prdata = '0;
    endcase
  end

endmodule

@@ rtl/stepper_trapezoid_step_planner.sv @@
// Top level of the stepper trapezoid step planner.
`timescale 1ns / 1ps
// Usage:
//   The input stream carries one word per request. tuser selects the kind:
//   0 plans and takes one step from the held position, 1 loads new_position.
//   The output stream returns exactly one word per request with the step flag,
//   direction pin, direction-change flag, microstep pins, speed, low time and
//   the position after the request. Configuration goes through the APB port,
//   which the user must write only while idle; the block does not enforce it.
// Flow:
//   A load word passes the load state and reaches the output once the output
//   register is free. A step word passes the setup states, the ramp divider
//   pass, the states that pick the mode, the low time divider pass and the
//   finish state, which also waits for a free output, then returns to idle.
//   One word is in flight at a time; s_tready is high only while idle.
// Reset:
//   rst clears the sequencer and the output valid, restores the register
//   defaults and sets position 0, full step, speed 120 rpm, low time 0.
// Backpressure:
//   The result is held on m_tdata until taken. A new word may be accepted
//   while it waits; the next result then holds in the sequencer until the
//   output register frees.
`include "stepper_trapezoid_step_planner_defines.svh"
module stepper_trapezoid_step_planner import stp_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  // s_tdata: start_position, target_position, new_position (low bits first)
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [IN_W-1:0]   s_tdata,
  // s_tuser: cmd
  input  logic              s_tuser,
  // m_tdata: step_taken, dir_cw, dir_changed, ms_pins, speed_out,
  //          low_time_us, position_out (low bits first)
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [OUT_W-1:0]  m_tdata,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  cfg_t      cfg;
  stp_cmd_t  cmd;
  stp_stat_t stat;

  // Register file never waits.
  assign pready = 1'b1;

  stp_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  // Sequencer: accepts a word, walks the datapath, owns the output valid.
  stp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_cmd    (s_tuser),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd),
    .stat     (stat)
  );

  // Datapath: its state registers double as the output word.
  stp_dp u_dp (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .cmd     (cmd),
    .stat    (stat),
    .s_tdata (s_tdata),
    .m_tdata (m_tdata)
  );

  // Output fields for the checks below.
  logic             out_step;
  logic [2:0]       out_ms;
  logic [SPD_W-1:0] out_speed;
  logic [LOW_W-1:0] out_low;
  logic             out_ms_ok;
  logic             out_stopped;
  logic             out_low_max;

  assign out_step    = m_tdata[OFS_STEP];
  assign out_ms      = m_tdata[OFS_MS +: 3];
  assign out_speed   = m_tdata[OFS_SPD +: SPD_W];
  assign out_low     = m_tdata[OFS_LOW +: LOW_W];
  assign out_ms_ok   = (out_ms == PINS_FULL) || (out_ms == PINS_HALF) ||
                       (out_ms == PINS_QUARTER) || (out_ms == PINS_EIGHTH) ||
                       (out_ms == PINS_SIXTEENTH);
  assign out_stopped = m_tvalid && out_step && (out_speed == '0);
  assign out_low_max = (out_low == LOW_W'(LOW_MAX));

  `STP_ASSERT_NEXT(a_single_item, s_tvalid && s_tready, !s_tready, "word taken while busy")
  `STP_ASSERT_IMPL(a_ms_code, m_tvalid, out_ms_ok, "illegal microstep pins")
  `STP_ASSERT_IMPL(a_low_clamp, m_tvalid, out_low <= LOW_W'(LOW_MAX), "low time above clamp")
  `STP_ASSERT_IMPL(a_zero_speed, out_stopped, out_low_max, "zero speed, short low time")

endmodule

@@ tb/sv/tb_top.sv @@
// Self-checking testbench for the stepper trapezoid step planner.
`timescale 1ns / 1ps
module tb_top;
  import stp_pkg::*;

  localparam int MAX_PRINTS = 40;

  // One output word, split into its fields.
  typedef struct {
    bit             step_taken;
    bit             dir_cw;
    bit             dir_changed;
    bit [2:0]       ms_pins;
    bit [SPD_W-1:0] speed;
    bit [LOW_W-1:0] low_time;
    bit [POS_W-1:0] position;
  } step_word_t;

  typedef enum int {
    SET_ALL_LOW,
    SET_ALL_HIGH,
    SET_RANDOM
  } settings_kind_t;

  // Planner state mirror plus the queue of result words still owed by the block.
  class planner_scoreboard;
    cfg_t                    regs;
    logic signed [POS_W-1:0] position;
    bit                      direction;
    mode_t                   mode;
    bit [SPD_W-1:0]          speed;
    bit [LOW_W-1:0]          low_time;
    step_word_t              pending[$];
    int                      errors;
    int                      checked;

    function new();
      regs.accel_span        = RESET_ACCEL_SPAN;
      regs.min_speed         = RESET_MIN_SPEED;
      regs.max_speed         = RESET_MAX_SPEED;
      regs.cw_positive       = 1'b1;
      regs.pulse_high_us     = RESET_PULSE_HIGH;
      regs.step_angle_milli  = RESET_ANGLE;
      regs.fine_thresholds   = RESET_FINE;
      regs.coarse_thresholds = RESET_COARSE;
      position  = '0;
      direction = 1'b0;
      mode      = MODE_FULL;
      speed     = SPD_W'(RESET_SPEED);
      low_time  = '0;
      errors    = 0;
      checked   = 0;
    endfunction

    task report(string msg);
      errors++;
      if (errors <= MAX_PRINTS) $display("[%0t] MISMATCH: %s", $time, msg);
    endtask

    function void apply_write(reg_idx_t idx, logic [DATA_W-1:0] value);
      case (idx)
        REG_ACCEL_SPAN: regs.accel_span        = value[CFG_W-1:0];
        REG_MIN_SPEED:  regs.min_speed         = value[CFG_W-1:0];
        REG_MAX_SPEED:  regs.max_speed         = value[CFG_W-1:0];
        REG_CW_POS:     regs.cw_positive       = value[0];
        REG_PULSE_HIGH: regs.pulse_high_us     = value[CFG_W-1:0];
        REG_ANGLE:      regs.step_angle_milli  = value[ANG_W-1:0];
        REG_FINE:       regs.fine_thresholds   = value;
        REG_COARSE:     regs.coarse_thresholds = value;
        default: ;
      endcase
    endfunction

    // Linear ramp from min_speed, slope fixed by the full acceleration span.
    function longint ramp_speed(longint d);
      longint span_l, s;
      span_l = (regs.accel_span != 0) ? longint'(regs.accel_span) : 64'sd1;
      s = longint'(regs.min_speed)
          + (d * (longint'(regs.max_speed) - longint'(regs.min_speed))) / span_l;
      if (s < 0) s = 0;
      if (s > longint'(SPD_TOP)) s = longint'(SPD_TOP);
      return s;
    endfunction

    function bit [2:0] pins_of(mode_t m);
      case (m)
        MODE_HALF:      return PINS_HALF;
        MODE_QUARTER:   return PINS_QUARTER;
        MODE_EIGHTH:    return PINS_EIGHTH;
        MODE_SIXTEENTH: return PINS_SIXTEENTH;
        default:        return PINS_FULL;
      endcase
    endfunction

    function void predict_request(bit load, logic signed [POS_W-1:0] move_from,
                                  logic signed [POS_W-1:0] move_to,
                                  logic signed [POS_W-1:0] load_pos);
      step_word_t w;
      longint     st, tg, p, travel, ramp_len, span_l, s, den, low;
      bit         up, dir, changed;
      int         div;
      w.step_taken = 1'b0;
      changed = 1'b0;
      if (load) begin
        position = load_pos;
      end else begin
        st = move_from;
        tg = move_to;
        p  = position;
        span_l = regs.accel_span;
        travel = (tg > st) ? tg - st : st - tg;
        ramp_len = (travel < 2 * span_l) ? travel / 2 : span_l;
        up = st < tg;
        if (up) begin
          if (p < st + ramp_len) s = ramp_speed(p - st);
          else if (p > tg - ramp_len) s = ramp_speed(tg - p);
          else s = regs.max_speed;
          dir = regs.cw_positive;
        end else begin
          if (p > st - ramp_len) s = ramp_speed(st - p);
          else if (p < tg + ramp_len) s = ramp_speed(p - tg);
          else s = regs.max_speed;
          dir = !regs.cw_positive;
        end
        changed   = (dir != direction);
        direction = dir;

        if (s <= longint'(regs.fine_thresholds[15:0])) mode = MODE_SIXTEENTH;
        else if (s <= longint'(regs.fine_thresholds[31:16])) mode = MODE_EIGHTH;
        else if (s <= longint'(regs.coarse_thresholds[15:0])) mode = MODE_QUARTER;
        else if (s <= longint'(regs.coarse_thresholds[31:16])) mode = MODE_HALF;
        else mode = MODE_FULL;
        div   = 1 << int'(mode);
        speed = s[SPD_W-1:0];

        if (s == 0) begin
          low = LOW_MAX;
        end else begin
          den = 3 * longint'(div) * s;
          low = (longint'(regs.step_angle_milli) * ANGLE_SCALE
                 - den * longint'(regs.pulse_high_us)) / den;
          if (low < 0) low = 0;
          if (low > LOW_MAX) low = LOW_MAX;
        end
        low_time = low[LOW_W-1:0];

        p = up ? p + 16 / div : p - 16 / div;
        position = p[POS_W-1:0];
        w.step_taken = 1'b1;
      end
      w.dir_cw      = direction;
      w.dir_changed = changed;
      w.ms_pins     = pins_of(mode);
      w.speed       = speed;
      w.low_time    = low_time;
      w.position    = position;
      pending.push_back(w);
    endfunction

    task compare_field(string name, longint got_v, longint want_v);
      if (got_v != want_v)
        report($sformatf("word %0d %s got %0d want %0d", checked, name, got_v, want_v));
    endtask

    task check_result(logic [OUT_W-1:0] word);
      step_word_t got, want;
      if (pending.size() == 0) begin
        report("result word arrived with no request outstanding");
        return;
      end
      want = pending.pop_front();
      checked++;
      if ($isunknown(word)) report($sformatf("word %0d has unknown bits", checked));
      got.step_taken  = word[OFS_STEP];
      got.dir_cw      = word[OFS_DIR];
      got.dir_changed = word[OFS_CHG];
      got.ms_pins     = word[OFS_MS +: 3];
      got.speed       = word[OFS_SPD +: SPD_W];
      got.low_time    = word[OFS_LOW +: LOW_W];
      got.position    = word[OFS_POS +: POS_W];
      compare_field("step_taken", got.step_taken, want.step_taken);
      compare_field("dir_cw", got.dir_cw, want.dir_cw);
      compare_field("dir_changed", got.dir_changed, want.dir_changed);
      compare_field("ms_pins", got.ms_pins, want.ms_pins);
      compare_field("speed_out", got.speed, want.speed);
      compare_field("low_time_us", got.low_time, want.low_time);
      compare_field("position_out", got.position, want.position);
    endtask
  endclass

  logic              clk;
  logic              rst;
  logic              s_tvalid;
  logic              s_tready;
  logic [IN_W-1:0]   s_tdata;
  logic              s_tuser;
  logic              m_tvalid;
  logic              m_tready;
  logic [OUT_W-1:0]  m_tdata;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  planner_scoreboard sb = new();
  bit                steady_flow;    // suppress idling on both sides
  int                n_plans;
  int                n_loads;
  int                n_settings;

  stepper_trapezoid_step_planner i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Receiver side: drop tready about a quarter of the cycles unless the
  // steady stretch is running. Drive on the falling edge only.
  always @(negedge clk) begin
    m_tready = steady_flow || ($urandom_range(0, 99) >= 25);
  end

  // Check every result word taken at a rising edge.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata);
  end

  function automatic logic signed [POS_W-1:0] rand_pos();
    logic [31:0] r;
    r = $urandom;
    return r[POS_W-1:0];
  endfunction

  // Offer one request word, wait for the handshake, then log its expected result.
  // Leave tvalid high afterwards so back-to-back words need no extra step.
  task automatic send_word(bit load, logic signed [POS_W-1:0] move_from,
                           logic signed [POS_W-1:0] move_to,
                           logic signed [POS_W-1:0] load_pos);
    int gap;
    gap = 0;
    if (!steady_flow && $urandom_range(0, 99) < 25)
      gap = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 120) : $urandom_range(1, 4);
    if (gap > 0) begin
      @(negedge clk);
      s_tvalid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    s_tvalid = 1'b1;
    s_tuser  = load;
    s_tdata  = IN_W'({load_pos, move_to, move_from});
    do @(posedge clk); while (!s_tready);
    sb.predict_request(load, move_from, move_to, load_pos);
    if (load) n_loads++;
    else n_plans++;
  endtask

  task automatic load_word(logic signed [POS_W-1:0] pos);
    send_word(1'b1, rand_pos(), rand_pos(), pos);
  endtask

  task automatic plan_word(logic signed [POS_W-1:0] move_from,
                           logic signed [POS_W-1:0] move_to);
    send_word(1'b0, move_from, move_to, rand_pos());
  endtask

  // Drop tvalid and hold until every owed word is back; the block is then idle
  // since each request yields exactly one result.
  task automatic finish_phase();
    @(negedge clk);
    s_tvalid = 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  // Two-phase APB write: setup, then access; the register takes the value at
  // the edge where psel, penable, pwrite and pready are all high.
  task automatic apb_write(reg_idx_t idx, logic [DATA_W-1:0] value);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = ADDR_W'(int'(idx) * 4);
    pwdata  = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    sb.apply_write(idx, value);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic load_settings(settings_kind_t kind);
    logic [DATA_W-1:0] v [8];
    int unsigned       th[$];
    int unsigned       top_spd, low_spd, hi, tmp;
    n_settings++;
    case (kind)
      SET_ALL_LOW: begin
        v = '{32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd1, 32'd0, 32'd0};
      end
      SET_ALL_HIGH: begin
        // High bits beyond each register's width must be dropped.
        v = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
              32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
      end
      default: begin
        top_spd = $urandom_range(0, 30000);
        low_spd = $urandom_range(0, 3000);
        // Now and then swap them so the ramp slopes downward.
        if ($urandom_range(0, 6) == 0) begin
          tmp = top_spd;
          top_spd = low_spd;
          low_spd = tmp;
        end
        case ($urandom_range(0, 9))
          0:          v[REG_ACCEL_SPAN] = 0;
          1:          v[REG_ACCEL_SPAN] = 32'h0000_FFFF;
          2, 3, 4, 5: v[REG_ACCEL_SPAN] = $urandom_range(1, 64);
          default:    v[REG_ACCEL_SPAN] = $urandom_range(65, 4000);
        endcase
        v[REG_MIN_SPEED]  = low_spd;
        v[REG_MAX_SPEED]  = top_spd;
        v[REG_CW_POS]     = $urandom;
        v[REG_PULSE_HIGH] = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 40);
        case ($urandom_range(0, 9))
          0, 1, 2: v[REG_ANGLE] = $urandom_range(1, 360000);
          3:       v[REG_ANGLE] = $urandom;
          default: v[REG_ANGLE] = $urandom_range(900, 3600);
        endcase
        if ($urandom_range(0, 7) == 0) begin
          v[REG_FINE]   = $urandom;
          v[REG_COARSE] = $urandom;
        end else begin
          // Spread ordered thresholds over the speed range so every mode shows.
          hi = ((top_spd > low_spd) ? top_spd : low_spd) + 1;
          repeat (4) th.push_back($urandom_range(0, hi + hi / 4));
          th.sort();
          v[REG_FINE]   = {th[1][15:0], th[0][15:0]};
          v[REG_COARSE] = {th[3][15:0], th[2][15:0]};
        end
      end
    endcase
    for (int i = 0; i < 8; i++) apb_write(reg_idx_t'(i), v[i]);
  endtask

  // Mostly whole moves: load a start point, then a run of plan words toward
  // the target, sometimes turning back. The rest is unrelated noise.
  task automatic run_moves(int count);
    int                      sent, steps;
    longint                  travel, st, tg, from;
    logic signed [POS_W-1:0] a, b, c;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(0, 99) < 78) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3: travel = $urandom_range(0, 64);
          4, 5, 6:    travel = $urandom_range(65, 6000);
          7, 8:       travel = $urandom_range(6001, 300000);
          default:    travel = $urandom_range(0, 8388607);
        endcase
        a  = rand_pos();
        st = a;
        tg = $urandom_range(0, 1) ? st + travel : st - travel;
        if (tg > 8388607 || tg < -8388608) tg = (tg > st) ? st - travel : st + travel;
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5: from = st;
          6, 7:             from = st + (tg - st) / 2;
          8:                from = tg - (tg - st) / 8;
          default:          from = rand_pos();
        endcase
        b = tg[POS_W-1:0];
        c = from[POS_W-1:0];
        load_word(c);
        sent++;
        steps = $urandom_range(1, 40);
        repeat (steps) plan_word(a, b);
        sent += steps;
        if ($urandom_range(0, 4) == 0) begin
          steps = $urandom_range(1, 10);
          repeat (steps) plan_word(b, a);
          sent += steps;
        end
      end else begin
        send_word($urandom_range(0, 1), rand_pos(), rand_pos(), rand_pos());
        sent++;
      end
    end
  endtask

  // Short directed pass at reset settings, then with a zero span,
  // reversed direction sense and a long high pulse.
  task automatic run_directed();
    load_word(0);
    plan_word(0, 3200);                   // ramp start at min speed
    load_word(1600);
    plan_word(0, 3200);                   // cruise at max speed
    load_word(3200);
    plan_word(0, 3200);                   // end of the decel ramp
    plan_word(3200, 0);                   // reverse: direction flips
    plan_word(100, 100);                  // equal ends move downward
    load_word(-24'sd8388608);
    plan_word(24'sd8388607, -24'sd8388608);  // step below the lowest position wraps
    load_word(24'sd8388607);
    plan_word(-24'sd8388608, 24'sd8388607);  // step above the highest position wraps
    load_word(50000);
    plan_word(0, 100);                    // far past target: speed clamps to zero
    load_word(-50000);
    plan_word(0, 100);                    // far before start: speed clamps to zero
    load_word(-1);
    load_word(24'sd4660);                 // back-to-back loads show held state
    finish_phase();

    n_settings++;
    apb_write(REG_ACCEL_SPAN, 32'd0);
    apb_write(REG_CW_POS, 32'hFFFF_FFFE);   // bit 0 clear, upper bits ignored
    apb_write(REG_PULSE_HIGH, 32'd60000);   // low time clamps to zero at nonzero speed
    load_word(-5);
    plan_word(0, 10);
    plan_word(0, 10);
    load_word(5);
    plan_word(10, 0);
    finish_phase();
    apb_write(REG_PULSE_HIGH, 32'd0);       // only legal while idle; drain first
  endtask

  initial begin
    int guard;
    rst         = 1'b1;
    s_tvalid    = 1'b0;
    s_tdata     = '0;
    s_tuser     = 1'b0;
    m_tready    = 1'b0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    steady_flow = 1'b0;
    n_plans     = 0;
    n_loads     = 0;
    n_settings  = 1;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    run_directed();

    load_settings(SET_ALL_LOW);
    run_moves(100);
    finish_phase();
    load_settings(SET_ALL_HIGH);
    run_moves(100);
    finish_phase();
    for (int ph = 0; ph < 7; ph++) begin
      load_settings(SET_RANDOM);
      steady_flow = (ph == 3);            // one long stretch with no idling
      run_moves(260);
      @(negedge clk);
      s_tvalid = 1'b0;
      steady_flow = 1'b0;
      finish_phase();
    end

    // Hold for stragglers, bounded, then let the pipeline settle.
    guard = 0;
    while (sb.pending.size() != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    if (sb.pending.size() != 0)
      sb.report($sformatf("%0d expected result words never arrived", sb.pending.size()));
    repeat (100) @(posedge clk);

    $display("Run covered %0d plan words and %0d position loads under %0d register settings.",
             n_plans, n_loads, n_settings);
    $display("%0d result words compared, %0d mismatches.", sb.checked, sb.errors);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog: a correct run ends far earlier than this.
  initial begin
    #6000000;
    $display("Timeout: run did not reach its end");
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/stp_pkg.sv
rtl/stp_div.sv
rtl/stp_ctrl.sv
rtl/stp_dp.sv
rtl/stp_regs.sv
rtl/stepper_trapezoid_step_planner.sv
tb/sv/tb_top.sv
